[rtl/core/deqbs_pkg.sv]
// Shared types and codes for the deque with bag search.
package deqbs_pkg;

	localparam int unsigned DataW = 32;

	typedef logic [2:0] func_t;
	localparam func_t FuncPushFront = 3'd0;
	localparam func_t FuncPushBack  = 3'd1;
	localparam func_t FuncPopFront  = 3'd2;
	localparam func_t FuncPopBack   = 3'd3;
	localparam func_t FuncContains  = 3'd4;
	localparam func_t FuncRemove    = 3'd5;

	typedef logic [1:0] status_t;
	localparam status_t StatusDone    = 2'd0;
	localparam status_t StatusDropped = 2'd1;
	localparam status_t StatusNone    = 2'd2;

	typedef struct packed {
		func_t              func;
		logic signed [31:0] value;
	} req_item_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic [4:0]         count;
		logic               is_empty;
		status_t            status;
	} rsp_item_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic               en;
		func_t              func;
		logic signed [31:0] value;
		logic               full;
		logic               empty;
	} cell_cmd_t;

endpackage

[rtl/core/deqbs_cell.sv]
// One storage cell of the deque chain: holds an entry, compares it and shifts.
module deqbs_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  deqbs_pkg::cell_cmd_t      cmd,
	input  logic signed [31:0]        left_data,
	input  logic                      left_occ,
	input  logic signed [31:0]        right_data,
	input  logic                      right_occ,
	input  logic                      match_in,
	output logic signed [31:0]        data,
	output logic                      occ,
	output logic                      match_out
);

	logic signed [31:0] data_q;
	logic               occ_q;
	logic               hit;

	assign hit       = occ_q && (data_q == cmd.value);
	assign match_out = match_in | hit;
	assign data      = data_q;
	assign occ       = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.en) begin
			case (cmd.func)
				deqbs_pkg::FuncPushFront: begin
					if (!cmd.full) begin
						occ_q <= left_occ;
					end
				end
				deqbs_pkg::FuncPushBack: begin
					if (!cmd.full && !occ_q && left_occ) begin
						occ_q <= 1'b1;
					end
				end
				deqbs_pkg::FuncPopFront: begin
					if (!cmd.empty) begin
						occ_q <= right_occ;
					end
				end
				deqbs_pkg::FuncPopBack: begin
					if (occ_q && !right_occ) begin
						occ_q <= 1'b0;
					end
				end
				deqbs_pkg::FuncRemove: begin
					if (match_out) begin
						occ_q <= right_occ;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			case (cmd.func)
				deqbs_pkg::FuncPushFront: begin
					if (!cmd.full) begin
						data_q <= left_data;
					end
				end
				deqbs_pkg::FuncPushBack: begin
					if (!cmd.full && !occ_q && left_occ) begin
						data_q <= cmd.value;
					end
				end
				deqbs_pkg::FuncPopFront: begin
					if (!cmd.empty) begin
						data_q <= right_data;
					end
				end
				deqbs_pkg::FuncRemove: begin
					if (match_out) begin
						data_q <= right_data;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/core/deque_with_bag_search.sv]
// Top level of the bounded double-ended queue with membership search.
// A bounded double-ended queue of signed 32-bit values that doubles as a bag.
// Each request transfer carries an operation (push front, push back, pop
// front, pop back, contains, remove first match) and a value; each one
// yields exactly one response transfer showing the queue after the
// operation: found, front and back entries (0 when empty), count, empty flag
// and a status (done, push dropped because full, nothing removed). The
// entries live in a row of CAPACITY identical cells, cell 0 at the front.
// Every cell compares its entry with the request value and passes a
// "matched at or before me" bit to its right-hand neighbor, so a search or a
// first-match removal completes within the execute step; front pushes and
// front pops move every entry one cell over in that same step, while a back
// push or pop changes only the back end. One request is in flight at a time:
// it is registered on transfer, then executed in the cell row, and its
// response is then built from the updated cells. req_stall stays high from a
// request transfer until its response has been transferred. Reset empties the
// queue at once; no clearing pass is needed.
module deque_with_bag_search #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  deqbs_pkg::req_item_t  req_item,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output deqbs_pkg::rsp_item_t  rsp_item
);

	localparam int unsigned CntW = $clog2(CAPACITY + 1);

	// Request register and pipeline flags.
	logic                   busy_q;
	logic                   valid_s1;
	deqbs_pkg::req_item_t   item_s1;
	logic                   valid_s2;
	logic                   found_s2;
	deqbs_pkg::status_t     status_s2;
	logic                   rsp_valid_q;
	deqbs_pkg::rsp_item_t   rsp_q;
	logic [CntW-1:0]        count_q;

	// Cell row wiring.
	logic signed [31:0]     cell_data [CAPACITY];
	logic [CAPACITY-1:0]    cell_occ;
	logic [CAPACITY:0]      match_chain;
	deqbs_pkg::cell_cmd_t   cmd;

	logic                   req_xfer;
	logic                   rsp_xfer;
	logic                   full;
	logic                   empty;
	logic                   found;
	logic                   found_rsp;
	deqbs_pkg::status_t     status;
	logic signed [31:0]     back_sel;
	logic [CntW+4:0]        count_ext;

	assign req_xfer  = req_valid && !req_stall;
	assign rsp_xfer  = rsp_valid && !rsp_stall;
	assign req_stall = busy_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	assign full  = cell_occ[CAPACITY-1];
	assign empty = !cell_occ[0];
	assign found = match_chain[CAPACITY];

	assign cmd = '{en: valid_s1, func: item_s1.func, value: item_s1.value,
		full: full, empty: empty};

	assign match_chain[0] = 1'b0;

	// The row of cells. Cell 0 sees the request value as an occupied left
	// neighbor, which makes a front push and a push into an empty queue fall
	// out of the generic shift rules; the last cell sees an empty right side.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_data;
		logic               left_occ;
		logic signed [31:0] right_data;
		logic               right_occ;

		if (i == 0) begin : g_first
			assign left_data = item_s1.value;
			assign left_occ  = 1'b1;
		end else begin : g_mid_l
			assign left_data = cell_data[i-1];
			assign left_occ  = cell_occ[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_data = '0;
			assign right_occ  = 1'b0;
		end else begin : g_mid_r
			assign right_data = cell_data[i+1];
			assign right_occ  = cell_occ[i+1];
		end

		deqbs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_data  (left_data),
			.left_occ   (left_occ),
			.right_data (right_data),
			.right_occ  (right_occ),
			.match_in   (match_chain[i]),
			.data       (cell_data[i]),
			.occ        (cell_occ[i]),
			.match_out  (match_chain[i+1])
		);
	end

	// Result flags of the operation being executed, from the state before it.
	always_comb begin
		status    = deqbs_pkg::StatusDone;
		found_rsp = 1'b0;
		case (item_s1.func)
			deqbs_pkg::FuncPushFront, deqbs_pkg::FuncPushBack: begin
				if (full) begin
					status = deqbs_pkg::StatusDropped;
				end
			end
			deqbs_pkg::FuncPopFront, deqbs_pkg::FuncPopBack: begin
				if (empty) begin
					status = deqbs_pkg::StatusNone;
				end
			end
			deqbs_pkg::FuncContains: begin
				found_rsp = found;
			end
			deqbs_pkg::FuncRemove: begin
				found_rsp = found;
				if (!found) begin
					status = deqbs_pkg::StatusNone;
				end
			end
			default: begin
			end
		endcase
	end

	// The back entry is the occupied cell whose right neighbor is empty.
	always_comb begin
		back_sel = '0;
		for (int unsigned k = 0; k < CAPACITY; k++) begin
			if (cell_occ[k] && (k == CAPACITY - 1 || !cell_occ[(k+1) % CAPACITY])) begin
				back_sel = back_sel | cell_data[k];
			end
		end
	end

	assign count_ext = {5'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			valid_s1 <= req_xfer;
			valid_s2 <= valid_s1;
			if (req_xfer) begin
				busy_q <= 1'b1;
			end else if (rsp_xfer) begin
				busy_q <= 1'b0;
			end
			if (valid_s2) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_xfer) begin
				rsp_valid_q <= 1'b0;
			end
			if (valid_s1) begin
				case (item_s1.func)
					deqbs_pkg::FuncPushFront, deqbs_pkg::FuncPushBack: begin
						if (!full) begin
							count_q <= count_q + CntW'(1);
						end
					end
					deqbs_pkg::FuncPopFront, deqbs_pkg::FuncPopBack: begin
						if (!empty) begin
							count_q <= count_q - CntW'(1);
						end
					end
					deqbs_pkg::FuncRemove: begin
						if (found) begin
							count_q <= count_q - CntW'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			item_s1 <= req_item;
		end
		if (valid_s1) begin
			found_s2  <= found_rsp;
			status_s2 <= status;
		end
		if (valid_s2) begin
			rsp_q.found       <= found_s2;
			rsp_q.front_value <= cell_occ[0] ? cell_data[0] : '0;
			rsp_q.back_value  <= back_sel;
			rsp_q.count       <= count_ext[4:0];
			rsp_q.is_empty    <= (count_q == '0);
			rsp_q.status      <= status_s2;
		end
	end

	// The cells are occupied as a prefix; this checks that the number of occupied cells equals the count.
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_occ) == 32'(count_q))
		else $error("cell occupancy disagrees with count");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("count exceeds capacity");

	a_rsp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> busy_q)
		else $error("response pending while block idle");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (!valid_s2 && !rsp_valid))
		else $error("more than one request in flight");

endmodule

[tb/deque_with_bag_search_tb.sv]
// Self-checking testbench for the deque with bag search, with its own predictor.
module deque_with_bag_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAP = 16;
	// The longest correct quiet spell is the long receiver hold-off in the back
	// pressure test; the watchdog limit sits well above it.
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned QUIET_LIMIT = 3000;
	// The tail leaves room for any response that should not be there.
	localparam int unsigned TAIL_CYCLES = 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	deqbs_pkg::req_item_t req_item = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	deqbs_pkg::rsp_item_t rsp_item;

	// Predicted contents of the queue, index 0 at the front.
	logic signed [31:0] held [CAP];
	int unsigned        held_n = 0;

	// Snapshots of the queue that the block is expected to report, oldest first.
	deqbs_pkg::rsp_item_t snapshot_q [$];

	int unsigned errors = 0;
	// When set, the sender and receiver draw random waits before each transfer.
	bit          idle_on = 1'b1;
	// A nonzero value makes the receiver stall that many cycles before its next
	// transfer; the receiver counts the cycles itself.
	int unsigned hold_len = 0;

	deque_with_bag_search #(
		.CAPACITY (CAP)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	always #5 clk = ~clk;

	// Apply one operation to the predicted queue and return the snapshot the
	// block must report afterwards.
	function automatic deqbs_pkg::rsp_item_t deque_apply(input deqbs_pkg::req_item_t op);
		deqbs_pkg::rsp_item_t r;
		int                   hit;
		r = '0;
		r.status = deqbs_pkg::StatusDone;
		hit = -1;
		case (op.func)
			deqbs_pkg::FuncPushFront: begin
				if (held_n >= CAP) begin
					r.status = deqbs_pkg::StatusDropped;
				end else begin
					for (int i = held_n; i > 0; i--)
						held[i] = held[i - 1];
					held[0] = op.value;
					held_n++;
				end
			end
			deqbs_pkg::FuncPushBack: begin
				if (held_n >= CAP) begin
					r.status = deqbs_pkg::StatusDropped;
				end else begin
					held[held_n] = op.value;
					held_n++;
				end
			end
			deqbs_pkg::FuncPopFront: begin
				if (held_n == 0) begin
					r.status = deqbs_pkg::StatusNone;
				end else begin
					for (int i = 0; i + 1 < held_n; i++)
						held[i] = held[i + 1];
					held_n--;
				end
			end
			deqbs_pkg::FuncPopBack: begin
				if (held_n == 0)
					r.status = deqbs_pkg::StatusNone;
				else
					held_n--;
			end
			deqbs_pkg::FuncContains: begin
				for (int i = 0; i < held_n; i++)
					if (held[i] == op.value)
						r.found = 1'b1;
			end
			deqbs_pkg::FuncRemove: begin
				for (int i = 0; i < held_n; i++)
					if (hit < 0 && held[i] == op.value)
						hit = i;
				if (hit >= 0) begin
					r.found = 1'b1;
					for (int i = hit; i + 1 < held_n; i++)
						held[i] = held[i + 1];
					held_n--;
				end else begin
					r.status = deqbs_pkg::StatusNone;
				end
			end
			default: begin
				// The two unused codes leave the queue alone.
			end
		endcase
		r.count = held_n[4:0];
		r.is_empty = (held_n == 0);
		r.front_value = (held_n > 0) ? held[0] : 32'sd0;
		r.back_value = (held_n > 0) ? held[held_n - 1] : 32'sd0;
		return r;
	endfunction

	// Offer one request and wait for its transfer. The task always returns at a
	// rising edge, so back-to-back requests keep req_valid high without a dip.
	task automatic send_op(input deqbs_pkg::func_t f, input logic signed [31:0] v);
		deqbs_pkg::req_item_t it;
		int unsigned          gap;
		it.func = f;
		it.value = v;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= it;
		do @(posedge clk); while (!(req_valid && !req_stall));
		snapshot_q.push_back(deque_apply(it));
	endtask

	// Lower req_valid and wait until every predicted response has come back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (snapshot_q.size() != 0)
			@(posedge clk);
	endtask

	// Values are drawn so that searches and removals hit often: held entries,
	// a narrow band with many duplicates, the extremes, and full random words.
	function automatic logic signed [31:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4 && held_n > 0)
			return held[$urandom_range(0, held_n - 1)];
		if (r < 6)
			return $signed($urandom_range(0, 7)) - 32'sd4;
		if (r < 8) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	// push_pct sets how often a push is drawn, which steers the fill level.
	function automatic deqbs_pkg::func_t pick_func(input int unsigned push_pct);
		int unsigned r;
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? deqbs_pkg::FuncPushBack : deqbs_pkg::FuncPushFront;
		r = $urandom_range(0, 99);
		if (r < 30) return deqbs_pkg::FuncPopFront;
		if (r < 55) return deqbs_pkg::FuncPopBack;
		if (r < 75) return deqbs_pkg::FuncContains;
		if (r < 97) return deqbs_pkg::FuncRemove;
		return deqbs_pkg::func_t'($urandom_range(6, 7));
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Receiver: stalls for a drawn number of cycles, takes one response and
	// compares it field by field with the oldest predicted snapshot.
	initial begin : response_side
		int unsigned          gap;
		deqbs_pkg::rsp_item_t want;
		forever begin
			if (hold_len > 0) begin
				gap = hold_len;
				hold_len = 0;
			end else begin
				gap = idle_on ? $urandom_range(0, 19) : 0;
			end
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
			if (snapshot_q.size() == 0) begin
				errors++;
				$display("%0t: response with none expected, actual %h", $time, rsp_item);
			end else begin
				want = snapshot_q.pop_front();
				check_field("found", want.found, rsp_item.found);
				check_field("front_value", want.front_value, rsp_item.front_value);
				check_field("back_value", want.back_value, rsp_item.back_value);
				check_field("count", want.count, rsp_item.count);
				check_field("is_empty", want.is_empty, rsp_item.is_empty);
				check_field("status", want.status, rsp_item.status);
			end
		end
	end

	// Watchdog: any cycle without a transfer on either channel counts toward
	// the limit; a transfer starts the count over.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Empty-queue cases, the value extremes, every operation, both unused
	// codes, hits and misses, and removal of the first of two duplicates.
	task automatic test_directed();
		send_op(deqbs_pkg::FuncPopFront, 32'sd0);
		send_op(deqbs_pkg::FuncPopBack, -32'sd1);
		send_op(deqbs_pkg::FuncContains, 32'sd0);
		send_op(deqbs_pkg::FuncRemove, 32'sd0);
		send_op(deqbs_pkg::func_t'(7), -32'sd1);
		send_op(deqbs_pkg::FuncPushFront, 32'sh7fff_ffff);
		send_op(deqbs_pkg::FuncPushBack, 32'sh8000_0000);
		send_op(deqbs_pkg::FuncPushFront, -32'sd1);
		send_op(deqbs_pkg::FuncPushBack, 32'sd0);
		send_op(deqbs_pkg::FuncPushBack, -32'sd1);
		send_op(deqbs_pkg::FuncContains, -32'sd1);
		send_op(deqbs_pkg::FuncContains, 32'sd5);
		send_op(deqbs_pkg::FuncRemove, 32'sd5);
		send_op(deqbs_pkg::FuncRemove, -32'sd1);
		send_op(deqbs_pkg::func_t'(6), 32'sh7fff_ffff);
		send_op(deqbs_pkg::FuncRemove, 32'sh8000_0000);
		send_op(deqbs_pkg::FuncPopBack, 32'sd0);
		send_op(deqbs_pkg::FuncPopFront, 32'sd0);
		send_op(deqbs_pkg::FuncRemove, 32'sd0);
		send_op(deqbs_pkg::FuncRemove, 32'sd0);
		send_op(deqbs_pkg::FuncPopFront, 32'sd0);
	endtask

	// Fill to capacity, push at both ends into the full store, work near the
	// top, then pop back down to empty.
	task automatic test_full_store();
		while (held_n < CAP)
			send_op($urandom_range(0, 1) ? deqbs_pkg::FuncPushBack : deqbs_pkg::FuncPushFront,
				pick_value());
		send_op(deqbs_pkg::FuncPushFront, 32'sh7fff_ffff);
		send_op(deqbs_pkg::FuncPushBack, 32'sh8000_0000);
		send_op(deqbs_pkg::FuncContains, held[CAP - 1]);
		send_op(deqbs_pkg::FuncRemove, held[CAP - 1]);
		send_op(deqbs_pkg::FuncPushBack, pick_value());
		send_op(deqbs_pkg::FuncRemove, held[0]);
		send_op(deqbs_pkg::FuncPushFront, pick_value());
		repeat (40)
			send_op(pick_func(held_n < CAP ? 60 : 50), pick_value());
		while (held_n > 0)
			send_op($urandom_range(0, 1) ? deqbs_pkg::FuncPopBack : deqbs_pkg::FuncPopFront,
				pick_value());
	endtask

	// Long random run in blocks whose push weight swings the fill level from
	// empty to full and back; some blocks run with no idling at all.
	task automatic test_random_mix(input int unsigned n_items);
		int unsigned push_pct;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 70;
					1: push_pct = 30;
					default: push_pct = 50;
				endcase
				idle_on = ($urandom_range(0, 3) != 0);
			end
			send_op(pick_func(push_pct), pick_value());
		end
		idle_on = 1'b1;
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering requests with no gaps, so the block stalls its input.
	task automatic test_back_pressure();
		idle_on = 1'b0;
		hold_len = HOLD_CYCLES;
		repeat (30)
			send_op(pick_func(50), pick_value());
		idle_on = 1'b1;
	endtask

	// The sender stops until every response is in, rests, and resumes.
	task automatic test_drain_pause();
		repeat (20)
			send_op(pick_func(50), pick_value());
		wait_drained();
		repeat (25) @(posedge clk);
		repeat (20)
			send_op(pick_func(50), pick_value());
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_store();
		test_random_mix(800);
		test_back_pressure();
		test_drain_pause();
		test_full_store();
		test_random_mix(850);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/core/deqbs_pkg.sv
rtl/core/deqbs_cell.sv
rtl/core/deque_with_bag_search.sv
tb/deque_with_bag_search_tb.sv
